[hdl/jsu_pkg.sv]
`default_nettype none

package jsu_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_BODY = 2'd1,
        MODE_ESC  = 2'd2,
        MODE_HEX  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_NO_QUOTE     = 3'd1,
        ERR_END_ESCAPE   = 3'd2,
        ERR_BAD_ESCAPE   = 3'd3,
        ERR_SHORT_HEX    = 3'd4,
        ERR_BAD_HEX      = 3'd5,
        ERR_UNTERMINATED = 3'd6
    } err_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_end;
    } text_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      out_kind;
        err_t       error_code;
        logic       run_last;
    } result_word_t;

    localparam logic [7:0]  CHAR_QUOTE  = 8'h22;
    localparam logic [7:0]  CHAR_BSLASH = 8'h5c;
    localparam logic [7:0]  CHAR_U      = 8'h75;
    localparam logic [15:0] CP_ONE_MAX  = 16'h007f;
    localparam logic [15:0] CP_TWO_MAX  = 16'h07ff;
    localparam logic [7:0]  UTF8_LEAD2  = 8'hc0;
    localparam logic [7:0]  UTF8_LEAD3  = 8'he0;
    localparam logic [7:0]  UTF8_CONT   = 8'h80;

    // Returns {valid, value} for one ASCII hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // Returns {valid, byte} for the single-byte escape letters.
    function automatic logic [8:0] escape_byte(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h22:   r = {1'b1, 8'h22};
            8'h5c:   r = {1'b1, 8'h5c};
            8'h2f:   r = {1'b1, 8'h2f};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0c};
            8'h6e:   r = {1'b1, 8'h0a};
            8'h72:   r = {1'b1, 8'h0d};
            8'h74:   r = {1'b1, 8'h09};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic result_word_t make_word(input logic [7:0] b, input kind_t k,
                                               input err_t e);
        result_word_t w;
        w.out_byte   = b;
        w.out_kind   = k;
        w.error_code = e;
        w.run_last   = 1'b0;
        return w;
    endfunction

endpackage

`default_nettype wire

[hdl/jsu_text_if.sv]
`default_nettype none

interface jsu_text_if;
    import jsu_pkg::*;

    logic       valid;
    logic       ready;
    text_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/jsu_result_if.sv]
`default_nettype none

interface jsu_result_if;
    import jsu_pkg::*;

    logic         valid;
    logic         ready;
    result_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/json_string_unescaper.sv]
`default_nettype none

// JSON string unescaper. Takes one text byte per cycle on the text channel
// while text.ready is high, and returns decoded string bytes, a completion word
// per closing quote, or an error word on the result channel. A text word goes
// into an input register and, once the result buffer can take its group, is
// decoded into up to three result words, which leave one per cycle from a
// three-entry result buffer while the result port is ready. With the port
// ready, the sustained rate is one text word per cycle, set by the result
// buffer: a \u escape that encodes to two or three UTF-8 bytes holds the port
// for one word per byte, and the input register absorbs one further word
// meanwhile. The last result word caused by a text word carries run_last.
module json_string_unescaper (
    input  wire logic    clk,
    input  wire logic    rst_n,
    jsu_text_if.sink     text,
    jsu_result_if.source result
);
    import jsu_pkg::*;

    mode_t        mode_reg, mode_next;
    logic [1:0]   hex_cnt_reg, hex_cnt_next;
    logic [11:0]  cp_reg, cp_next;

    logic         in_full_reg, in_full_next;
    text_word_t   in_word_reg;

    result_word_t slot_reg [3];
    logic [1:0]   rem_reg, rem_next;

    result_word_t dec_res [3];
    logic [1:0]   dec_cnt;

    logic [7:0]   c;
    logic         e;
    logic         hex_ok;
    logic [3:0]   hex_val;
    logic [15:0]  cp_full;
    logic         esc_ok;
    logic [7:0]   esc_val;
    logic         pop;
    logic         drain_ok;
    logic         load;
    logic         take;

    assign c               = in_word_reg.in_byte;
    assign e               = in_word_reg.text_end;
    assign {hex_ok, hex_val} = hex_digit(c);
    assign {esc_ok, esc_val} = escape_byte(c);
    assign cp_full         = {cp_reg, hex_val};

    assign pop      = (rem_reg != 2'd0) && result.ready;
    // The buffer can take a new group when empty or when its last word leaves now.
    assign drain_ok = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && result.ready);
    assign load     = in_full_reg && drain_ok;
    assign take     = text.valid && text.ready;

    assign text.ready   = !in_full_reg || load;
    assign result.valid = (rem_reg != 2'd0);
    assign result.data  = slot_reg[0];

    always_comb
    begin
        mode_next    = mode_reg;
        hex_cnt_next = hex_cnt_reg;
        cp_next      = cp_reg;
        case (mode_reg)
            MODE_IDLE:
            begin
                if (!e && (c == CHAR_QUOTE))
                begin
                    mode_next = MODE_BODY;
                end
            end
            MODE_BODY:
            begin
                if (e || (c == CHAR_QUOTE))
                begin
                    mode_next = MODE_IDLE;
                end
                else if (c == CHAR_BSLASH)
                begin
                    mode_next = MODE_ESC;
                end
            end
            MODE_ESC:
            begin
                if (e)
                begin
                    mode_next = MODE_IDLE;
                end
                else if (c == CHAR_U)
                begin
                    mode_next    = MODE_HEX;
                    hex_cnt_next = 2'd0;
                    cp_next      = 12'd0;
                end
                else if (esc_ok)
                begin
                    mode_next = MODE_BODY;
                end
                else
                begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_HEX:
            begin
                if (e || !hex_ok)
                begin
                    mode_next    = MODE_IDLE;
                    hex_cnt_next = 2'd0;
                    cp_next      = 12'd0;
                end
                else if (hex_cnt_reg == 2'd3)
                begin
                    mode_next    = MODE_BODY;
                    hex_cnt_next = 2'd0;
                    cp_next      = 12'd0;
                end
                else
                begin
                    hex_cnt_next = hex_cnt_reg + 2'd1;
                    cp_next      = cp_full[11:0];
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

    always_comb
    begin
        dec_cnt    = 2'd0;
        dec_res[0] = make_word(8'h00, KIND_DATA, ERR_NONE);
        dec_res[1] = make_word(8'h00, KIND_DATA, ERR_NONE);
        dec_res[2] = make_word(8'h00, KIND_DATA, ERR_NONE);
        case (mode_reg)
            MODE_IDLE:
            begin
                if (e || !(c inside {8'h20, 8'h09, 8'h0d, 8'h0a, CHAR_QUOTE}))
                begin
                    dec_cnt    = 2'd1;
                    dec_res[0] = make_word(8'h00, KIND_ERR, ERR_NO_QUOTE);
                end
            end
            MODE_BODY:
            begin
                if (e)
                begin
                    dec_cnt    = 2'd1;
                    dec_res[0] = make_word(8'h00, KIND_ERR, ERR_UNTERMINATED);
                end
                else if (c == CHAR_QUOTE)
                begin
                    dec_cnt    = 2'd1;
                    dec_res[0] = make_word(8'h00, KIND_DONE, ERR_NONE);
                end
                else if (c != CHAR_BSLASH)
                begin
                    dec_cnt    = 2'd1;
                    dec_res[0] = make_word(c, KIND_DATA, ERR_NONE);
                end
            end
            MODE_ESC:
            begin
                if (e)
                begin
                    dec_cnt    = 2'd1;
                    dec_res[0] = make_word(8'h00, KIND_ERR, ERR_END_ESCAPE);
                end
                else if (esc_ok)
                begin
                    dec_cnt    = 2'd1;
                    dec_res[0] = make_word(esc_val, KIND_DATA, ERR_NONE);
                end
                else if (c != CHAR_U)
                begin
                    dec_cnt    = 2'd1;
                    dec_res[0] = make_word(8'h00, KIND_ERR, ERR_BAD_ESCAPE);
                end
            end
            MODE_HEX:
            begin
                if (e)
                begin
                    dec_cnt    = 2'd1;
                    dec_res[0] = make_word(8'h00, KIND_ERR, ERR_SHORT_HEX);
                end
                else if (!hex_ok)
                begin
                    dec_cnt    = 2'd1;
                    dec_res[0] = make_word(8'h00, KIND_ERR, ERR_BAD_HEX);
                end
                else if (hex_cnt_reg == 2'd3)
                begin
                    if (cp_full <= CP_ONE_MAX)
                    begin
                        dec_cnt    = 2'd1;
                        dec_res[0] = make_word(cp_full[7:0], KIND_DATA, ERR_NONE);
                    end
                    else if (cp_full <= CP_TWO_MAX)
                    begin
                        dec_cnt    = 2'd2;
                        dec_res[0] = make_word(UTF8_LEAD2 | {3'd0, cp_full[10:6]},
                                               KIND_DATA, ERR_NONE);
                        dec_res[1] = make_word(UTF8_CONT | {2'd0, cp_full[5:0]},
                                               KIND_DATA, ERR_NONE);
                    end
                    else
                    begin
                        dec_cnt    = 2'd3;
                        dec_res[0] = make_word(UTF8_LEAD3 | {4'd0, cp_full[15:12]},
                                               KIND_DATA, ERR_NONE);
                        dec_res[1] = make_word(UTF8_CONT | {2'd0, cp_full[11:6]},
                                               KIND_DATA, ERR_NONE);
                        dec_res[2] = make_word(UTF8_CONT | {2'd0, cp_full[5:0]},
                                               KIND_DATA, ERR_NONE);
                    end
                end
            end
            default:
            begin
                dec_cnt = 2'd0;
            end
        endcase
        case (dec_cnt)
            2'd1:    dec_res[0].run_last = 1'b1;
            2'd2:    dec_res[1].run_last = 1'b1;
            2'd3:    dec_res[2].run_last = 1'b1;
            default: dec_res[0].run_last = 1'b0;
        endcase
    end

    always_comb
    begin
        in_full_next = in_full_reg;
        if (take)
        begin
            in_full_next = 1'b1;
        end
        else if (load)
        begin
            in_full_next = 1'b0;
        end
    end

    always_comb
    begin
        rem_next = rem_reg;
        if (load)
        begin
            rem_next = dec_cnt;
        end
        else if (pop)
        begin
            rem_next = rem_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            hex_cnt_reg <= 2'd0;
            cp_reg      <= 12'd0;
            in_full_reg <= 1'b0;
            rem_reg     <= 2'd0;
        end
        else
        begin
            in_full_reg <= in_full_next;
            rem_reg     <= rem_next;
            if (load)
            begin
                mode_reg    <= mode_next;
                hex_cnt_reg <= hex_cnt_next;
                cp_reg      <= cp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_word_reg <= text.data;
        end
        if (load)
        begin
            slot_reg[0] <= dec_res[0];
            slot_reg[1] <= dec_res[1];
            slot_reg[2] <= dec_res[2];
        end
        else if (pop)
        begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

    // A completion or error word always closes the group of its text word.
    a_final_word_last : assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.data.out_kind != KIND_DATA)) |-> result.data.run_last)
        else $error("completion or error word without run_last");

    a_code_matches_kind : assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |->
            ((result.data.out_kind == KIND_ERR) == (result.data.error_code != ERR_NONE)))
        else $error("error code does not match word kind");

    // Decoding state only advances when the held text word is consumed.
    a_state_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !$past(load) |-> $stable(mode_reg) && $stable(hex_cnt_reg))
        else $error("decode state changed without a consumed text word");

    a_ready_stall : assert property (@(posedge clk) disable iff (!rst_n)
        !text.ready |-> (in_full_reg && (rem_reg != 2'd0)))
        else $error("text channel stalled with room to accept");

endmodule

`default_nettype wire
